// File: rtl/cfe_pkg.sv
// Package for the cuckoo filter engine: field widths, codes, reset values,
// and the command and status types shared by the controller and the datapath.
`timescale 1ns / 1ps
package cfe_pkg;

    localparam int DEF_MAX_BUCKETS_LOG2 = 10;
    localparam int DEF_SLOTS_PER_BUCKET = 4;

    localparam int FP_W       = 16;
    localparam int KEY_W      = 32;
    localparam int OP_W       = 2;
    localparam int OCC_OUT_W  = 13;
    localparam int FAIL_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LG_W       = 4;
    localparam int SLOTS_W    = 3;
    localparam int KICK_W     = 10;
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS  = KEY_W / MOD_BITS_PER_STEP;

    localparam logic [LG_W-1:0]    RST_BUCKET_LOG2 = 4'd10;
    localparam logic [SLOTS_W-1:0] RST_SLOTS       = 3'd4;
    localparam logic [KICK_W-1:0]  RST_MAX_KICKS   = 10'd500;
    localparam logic [KEY_W-1:0]   RST_SEED        = 32'd1;
    localparam logic [OCC_OUT_W-1:0] OCC_OUT_MAX   = '1;
    localparam logic [FAIL_W-1:0]  FAIL_MAX        = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_LOG2 = 2'd0,
        CFG_SLOTS       = 2'd1,
        CFG_MAX_KICKS   = 2'd2,
        CFG_SEED        = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RD_B1  = 2'd0,
        RD_B2  = 2'd1,
        RD_CUR = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    place;
        logic    clear;
        logic    pick;
        logic    kick;
        logic    mod_step;
        logic    swap;
        logic    fail;
        logic    out_load;
        logic    out_ok;
        logic    clr_step;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic has_empty;
        logic has_match;
        logic mod_done;
        logic kicks_left;
        logic no_kicks;
        logic clr_last;
        logic out_full;
    } sts_t;

    function automatic logic [KEY_W-1:0] xorshift32(input logic [KEY_W-1:0] x);
        logic [KEY_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

// File: rtl/cfe_if.sv
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on cfe_pkg for the field widths.
`timescale 1ns / 1ps
interface cfe_req_if;
    logic                      valid;
    logic                      ready;
    logic [cfe_pkg::OP_W-1:0]  operation;
    logic [cfe_pkg::KEY_W-1:0] key_hash;
    modport source (output valid, operation, key_hash, input ready);
    modport sink (input valid, operation, key_hash, output ready);
endinterface

interface cfe_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          success;
    logic [cfe_pkg::OCC_OUT_W-1:0] occupied_count;
    logic [cfe_pkg::FAIL_W-1:0]    failed_inserts;
    modport source (output valid, success, occupied_count, failed_inserts, input ready);
    modport sink (input valid, success, occupied_count, failed_inserts, output ready);
endinterface

interface cfe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cfe_pkg::CFG_IDX_W-1:0]  index;
    logic [cfe_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/cfe_ctrl.sv
// Controller state machine of the cuckoo filter engine.
// Depends on cfe_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module cfe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cfe_pkg::sts_t sts,
    output cfe_pkg::cmd_t cmd
);
    import cfe_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RD1   = 11'b00000000100,
        S_CHK1  = 11'b00000001000,
        S_RD2   = 11'b00000010000,
        S_CHK2  = 11'b00000100000,
        S_KICK  = 11'b00001000000,
        S_MOD   = 11'b00010000000,
        S_SWAP  = 11'b00100000000,
        S_CHKC  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;
    logic   rdc_reg, rdc_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        rdc_next   = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RD_B1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    ok_next    = 1'b0;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_B1;
                state_next = S_CHK1;
            end
            S_CHK1:
            begin
                state_next = S_RD2;
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (sts.has_empty)
                        begin
                            cmd.place  = 1'b1;
                            ok_next    = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (sts.has_match)
                        begin
                            ok_next    = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (sts.has_match)
                        begin
                            cmd.clear  = 1'b1;
                            ok_next    = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_B2;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                state_next = S_DONE;
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (sts.has_empty)
                        begin
                            cmd.place = 1'b1;
                            ok_next   = 1'b1;
                        end
                        else
                        begin
                            cmd.pick = 1'b1;
                            if (sts.no_kicks)
                            begin
                                cmd.fail = 1'b1;
                            end
                            else
                            begin
                                state_next = S_KICK;
                            end
                        end
                    end
                    OP_LOOKUP:
                    begin
                        ok_next = sts.has_match;
                    end
                    OP_REMOVE:
                    begin
                        cmd.clear = sts.has_match;
                        ok_next   = sts.has_match;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_KICK:
            begin
                cmd.kick   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                if (rdc_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_CHKC;
                end
                else
                begin
                    cmd.swap = 1'b1;
                    rdc_next = 1'b1;
                end
            end
            S_CHKC:
            begin
                if (sts.has_empty)
                begin
                    cmd.place  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.kicks_left)
                begin
                    state_next = S_KICK;
                end
                else
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = ok_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ok_reg    <= 1'b0;
            rdc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            rdc_reg   <= rdc_next;
        end
    end

    a_place_needs_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> sts.has_empty)
        else $error("Insert wrote a bucket without a free slot.");
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_RD1)
        else $error("Accepted transaction did not start a bucket read.");
    a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == S_IDLE)
        else $error("Response loaded outside the completion step.");
endmodule

// File: rtl/cfe_dp.sv
// Datapath of the cuckoo filter engine: bucket memory, configuration,
// victim generator, slot remainder unit, counters and the response register.
`timescale 1ns / 1ps
module cfe_dp #(
    parameter int MAX_BUCKETS_LOG2 = cfe_pkg::DEF_MAX_BUCKETS_LOG2,
    parameter int SLOTS_PER_BUCKET = cfe_pkg::DEF_SLOTS_PER_BUCKET
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfe_pkg::cmd_t                  cmd,
    output cfe_pkg::sts_t                  sts,
    input  logic [cfe_pkg::OP_W-1:0]       in_operation,
    input  logic [cfe_pkg::KEY_W-1:0]      in_key_hash,
    input  logic                           cfg_we,
    input  logic [cfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_success,
    output logic [cfe_pkg::OCC_OUT_W-1:0]  out_occupied_count,
    output logic [cfe_pkg::FAIL_W-1:0]     out_failed_inserts
);
    import cfe_pkg::*;

    localparam int BW      = MAX_BUCKETS_LOG2;
    localparam int S       = SLOTS_PER_BUCKET;
    localparam int ROWS    = 1 << BW;
    localparam int ROW_W   = S * FP_W;
    localparam int DEPTH   = S << BW;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int SLOT_IW = (S > 1) ? $clog2(S) : 1;
    localparam int REM_W   = SLOT_IW + 1;
    localparam int NW      = $clog2(S + 1);
    localparam int MSW     = $clog2(MOD_STEPS);

    logic [LG_W-1:0]    lg_reg;
    logic [SLOTS_W-1:0] slots_reg;
    logic [KICK_W-1:0]  kicks_reg;
    logic [KEY_W-1:0]   rng_reg;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rdata_reg;
    logic [BW-1:0]    addr_reg;
    logic [BW-1:0]    clr_reg;

    op_t              op_reg;
    logic [FP_W-1:0]  fp_reg;
    logic [BW-1:0]    b1_reg, b2_reg, cur_reg;
    logic [KICK_W-1:0] kcount_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [FAIL_W-1:0] fail_reg;
    logic [KEY_W-1:0] msrc_reg;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MSW-1:0]   mcnt_reg;

    logic [BW-1:0]    mask;
    logic [NW-1:0]    n_c;
    logic [FP_W-1:0]  fp_in;
    logic [BW-1:0]    b1_in;
    logic [BW-1:0]    raddr;
    logic             we;
    logic [BW-1:0]    waddr;
    logic [ROW_W-1:0] wdata;
    logic [SLOT_IW-1:0] empty_idx, match_idx;
    logic             has_empty, has_match;
    logic [KEY_W-1:0] rng_adv;
    logic [FP_W-1:0]  victim;
    logic [SLOT_IW-1:0] kslot;

    function automatic logic [BW-1:0] alt_bucket(input logic [BW-1:0] b,
                                                 input logic [FP_W-1:0] fp,
                                                 input logic [BW-1:0] m);
        logic [KEY_W-1:0] t;
        t = {{(KEY_W-FP_W){1'b0}}, fp} >> 1;
        return (b ^ t[BW-1:0]) & m;
    endfunction

    always_comb
    begin
        int lg;
        lg = int'(lg_reg);
        if (lg < 1)
        begin
            lg = 1;
        end
        if (lg > BW)
        begin
            lg = BW;
        end
        for (int i = 0; i < BW; i++)
        begin
            mask[i] = (i < lg);
        end
        if (int'(slots_reg) < 1)
        begin
            n_c = NW'(1);
        end
        else if (int'(slots_reg) > S)
        begin
            n_c = NW'(S);
        end
        else
        begin
            n_c = NW'(slots_reg);
        end
    end

    assign fp_in   = (in_key_hash[FP_W-1:0] == '0) ? FP_W'(1) : in_key_hash[FP_W-1:0];
    assign b1_in   = in_key_hash[BW-1:0] & mask;
    assign rng_adv = xorshift32(rng_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_B1:   raddr = b1_reg;
            RD_B2:   raddr = b2_reg;
            RD_CUR:  raddr = cur_reg;
            default: raddr = b1_reg;
        endcase
    end

    always_comb
    begin
        has_empty = 1'b0;
        has_match = 1'b0;
        empty_idx = '0;
        match_idx = '0;
        for (int s = S - 1; s >= 0; s--)
        begin
            if (s < int'(n_c))
            begin
                if (rdata_reg[s*FP_W +: FP_W] == '0)
                begin
                    has_empty = 1'b1;
                    empty_idx = SLOT_IW'(s);
                end
                if (rdata_reg[s*FP_W +: FP_W] == fp_reg)
                begin
                    has_match = 1'b1;
                    match_idx = SLOT_IW'(s);
                end
            end
        end
    end

    assign kslot  = rem_reg[SLOT_IW-1:0];
    assign victim = rdata_reg[kslot*FP_W +: FP_W];

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = rdata_reg;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (cmd.place)
        begin
            we = 1'b1;
            wdata[empty_idx*FP_W +: FP_W] = fp_reg;
        end
        else if (cmd.clear)
        begin
            we = 1'b1;
            wdata[match_idx*FP_W +: FP_W] = '0;
        end
        else if (cmd.swap)
        begin
            we = 1'b1;
            wdata[kslot*FP_W +: FP_W] = fp_reg;
        end
    end

    always_comb
    begin
        logic [REM_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < MOD_BITS_PER_STEP; i++)
        begin
            r = {r[REM_W-1:0], msrc_reg[KEY_W-1-i]};
            if (r >= (REM_W+1)'(n_c))
            begin
                r = r - (REM_W+1)'(n_c);
            end
        end
        rem_next = r[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            addr_reg <= raddr;
        end
        if (cmd.load)
        begin
            op_reg <= op_t'(in_operation);
            fp_reg <= fp_in;
            b1_reg <= b1_in;
            b2_reg <= alt_bucket(b1_in, fp_in, mask);
        end
        else if (cmd.swap)
        begin
            fp_reg <= victim;
        end
        if (cmd.pick)
        begin
            cur_reg <= rng_adv[0] ? b1_reg : b2_reg;
        end
        else if (cmd.swap)
        begin
            cur_reg <= alt_bucket(cur_reg, victim, mask);
        end
        if (cmd.kick)
        begin
            msrc_reg <= rng_adv;
            rem_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            msrc_reg <= msrc_reg << MOD_BITS_PER_STEP;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_reg      <= RST_BUCKET_LOG2;
            slots_reg   <= RST_SLOTS;
            kicks_reg   <= RST_MAX_KICKS;
            rng_reg     <= RST_SEED;
            clr_reg     <= '0;
            kcount_reg  <= '0;
            mcnt_reg    <= '0;
            occ_reg     <= '0;
            fail_reg    <= '0;
            out_valid   <= 1'b0;
            out_success <= 1'b0;
            out_occupied_count <= '0;
            out_failed_inserts <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BUCKET_LOG2: lg_reg    <= cfg_data[LG_W-1:0];
                    CFG_SLOTS:       slots_reg <= cfg_data[SLOTS_W-1:0];
                    CFG_MAX_KICKS:   kicks_reg <= cfg_data[KICK_W-1:0];
                    CFG_SEED:        rng_reg   <= (cfg_data == '0) ? KEY_W'(1) : cfg_data;
                    default:         lg_reg    <= lg_reg;
                endcase
            end
            else if (cmd.pick || cmd.kick)
            begin
                rng_reg <= rng_adv;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (cmd.pick)
            begin
                kcount_reg <= '0;
            end
            else if (cmd.swap)
            begin
                kcount_reg <= kcount_reg + KICK_W'(1);
            end
            if (cmd.kick)
            begin
                mcnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mcnt_reg <= mcnt_reg + MSW'(1);
            end
            if (cmd.place)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (cmd.clear && occ_reg != '0)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
            if (cmd.fail && fail_reg != FAIL_MAX)
            begin
                fail_reg <= fail_reg + FAIL_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid   <= 1'b1;
                out_success <= cmd.out_ok;
                out_occupied_count <= (32'(occ_reg) > 32'(OCC_OUT_MAX)) ?
                                      OCC_OUT_MAX : OCC_OUT_W'(occ_reg);
                out_failed_inserts <= fail_reg;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign sts.op         = op_reg;
    assign sts.has_empty  = has_empty;
    assign sts.has_match  = has_match;
    assign sts.mod_done   = (mcnt_reg == MSW'(MOD_STEPS - 1));
    assign sts.kicks_left = (kcount_reg != kicks_reg);
    assign sts.no_kicks   = (kicks_reg == '0);
    assign sts.clr_last   = (clr_reg == BW'(ROWS - 1));
    assign sts.out_full   = out_valid && !out_ready;

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= 32'(DEPTH))
        else $error("Occupied slot count exceeds the store depth.");
    a_fail_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg >= $past(fail_reg))
        else $error("Failed insert count went down.");
    a_kick_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap |-> kcount_reg < kicks_reg)
        else $error("Relocation ran past the kick limit.");
endmodule

// File: rtl/cuckoo_filter_engine_unit.sv
// Cuckoo filter engine: a request reads its primary bucket and, when that does not decide it,
// its alternate bucket; each relocation of an insert runs the kick read, the remainder unit,
// the swap and the read of the next bucket. The next request can be taken in the cycle after
// the response is loaded; a stalled response holds the engine.
// After reset a clearing pass empties all 2**MAX_BUCKETS_LOG2 rows of the store;
// requests wait for it, configuration writes are taken at once.
`timescale 1ns / 1ps
module cuckoo_filter_engine_unit #(
    parameter int MAX_BUCKETS_LOG2 = cfe_pkg::DEF_MAX_BUCKETS_LOG2,
    parameter int SLOTS_PER_BUCKET = cfe_pkg::DEF_SLOTS_PER_BUCKET
) (
    input logic   clk,
    input logic   rst_n,
    cfe_req_if.sink   req,
    cfe_rsp_if.source rsp,
    cfe_cfg_if.sink   cfg
);
    import cfe_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    cfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfe_dp #(
        .MAX_BUCKETS_LOG2 (MAX_BUCKETS_LOG2),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .in_operation       (req.operation),
        .in_key_hash        (req.key_hash),
        .cfg_we             (cfg.valid),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_success        (rsp.success),
        .out_occupied_count (rsp.occupied_count),
        .out_failed_inserts (rsp.failed_inserts)
    );
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for cuckoo_filter_engine_unit: random and directed
// insert, lookup and remove transactions checked against an internal filter model.
// Depends on cfe_pkg, the channel interfaces in rtl/cfe_if.sv and the RTL top.
`timescale 1ns / 1ps

class filter_scoreboard;
    typedef struct packed {
        logic                          ok;
        logic [cfe_pkg::OCC_OUT_W-1:0] occ;
        logic [cfe_pkg::FAIL_W-1:0]    fails;
    } outcome_t;

    logic [3:0]  lg_reg;
    logic [2:0]  slots_reg;
    logic [9:0]  kicks_reg;
    logic [15:0] slots_mem [0:4095];
    int unsigned occ_total;
    logic [31:0] fail_total;
    logic [31:0] rnd;
    outcome_t    pending [$];
    int          errors;
    int          checked;

    function new();
        lg_reg = 4'd10;
        slots_reg = 3'd4;
        kicks_reg = 10'd500;
        foreach (slots_mem[i]) slots_mem[i] = '0;
        occ_total = 0;
        fail_total = '0;
        rnd = 32'd1;
        errors = 0;
        checked = 0;
    endfunction

    function void write_reg(cfe_pkg::cfg_idx_t idx, logic [31:0] d);
        case (idx)
            cfe_pkg::CFG_BUCKET_LOG2: lg_reg = d[3:0];
            cfe_pkg::CFG_SLOTS:       slots_reg = d[2:0];
            cfe_pkg::CFG_MAX_KICKS:   kicks_reg = d[9:0];
            cfe_pkg::CFG_SEED:        rnd = (d == 0) ? 32'd1 : d;
            default: ;
        endcase
    endfunction

    function logic [31:0] step_rnd();
        logic [31:0] x;
        x = rnd;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rnd = x;
        return x;
    endfunction

    function int unsigned nslots();
        if (slots_reg < 1) return 1;
        if (slots_reg > 4) return 4;
        return 32'(slots_reg);
    endfunction

    function logic [31:0] bmask();
        int unsigned lg;
        lg = 32'(lg_reg);
        if (lg < 1) lg = 1;
        if (lg > 10) lg = 10;
        return (32'd1 << lg) - 32'd1;
    endfunction

    function bit try_place(logic [31:0] b, logic [15:0] fp);
        for (int s = 0; s < nslots(); s++)
            if (slots_mem[(b * 4 + s) % 4096] == 0) begin
                slots_mem[(b * 4 + s) % 4096] = fp;
                occ_total++;
                return 1;
            end
        return 0;
    endfunction

    function bit has_fp(logic [31:0] b, logic [15:0] fp);
        for (int s = 0; s < nslots(); s++)
            if (slots_mem[(b * 4 + s) % 4096] == fp) return 1;
        return 0;
    endfunction

    function bit drop_fp(logic [31:0] b, logic [15:0] fp);
        for (int s = 0; s < nslots(); s++)
            if (slots_mem[(b * 4 + s) % 4096] == fp) begin
                slots_mem[(b * 4 + s) % 4096] = 0;
                if (occ_total > 0) occ_total--;
                return 1;
            end
        return 0;
    endfunction

    function bit insert_fp(logic [31:0] b1, logic [31:0] b2, logic [15:0] fp,
                           logic [31:0] m);
        logic [31:0] cur;
        logic [31:0] r;
        logic [15:0] victim;
        int unsigned e;
        if (try_place(b1, fp) || try_place(b2, fp)) return 1;
        r = step_rnd();
        cur = r[0] ? b1 : b2;
        for (int k = 0; k < kicks_reg; k++) begin
            r = step_rnd();
            e = (cur * 4 + r % nslots()) % 4096;
            victim = slots_mem[e];
            slots_mem[e] = fp;
            fp = victim;
            cur = (cur ^ (fp >> 1)) & m;
            if (try_place(cur, fp)) return 1;
        end
        if (fail_total != 32'hffff_ffff) fail_total++;
        return 0;
    endfunction

    function void note_request(cfe_pkg::op_t op, logic [31:0] h);
        logic [15:0] fp;
        logic [31:0] m, b1, b2;
        outcome_t o;
        fp = h[15:0];
        if (fp == 0) fp = 1;
        m = bmask();
        b1 = h & m;
        b2 = (b1 ^ (fp >> 1)) & m;
        o.ok = 0;
        case (op)
            cfe_pkg::OP_INSERT: o.ok = insert_fp(b1, b2, fp, m);
            cfe_pkg::OP_LOOKUP: o.ok = has_fp(b1, fp) || has_fp(b2, fp);
            cfe_pkg::OP_REMOVE: o.ok = drop_fp(b1, fp) || drop_fp(b2, fp);
            default: ;
        endcase
        o.occ = (occ_total > 8191) ? 13'd8191 : occ_total[12:0];
        o.fails = fail_total;
        pending.push_back(o);
    endfunction

    function void check_response(logic ok, logic [12:0] occ, logic [31:0] fails);
        outcome_t o;
        if (pending.size() == 0) begin
            $display("%0t: response with none expected: ok=%0d occ=%0d fails=%0d",
                     $time, ok, occ, fails);
            errors++;
            return;
        end
        o = pending.pop_front();
        checked++;
        if (o.ok !== ok) begin
            $display("%0t: success expected %0d actual %0d", $time, o.ok, ok);
            errors++;
        end
        if (o.occ !== occ) begin
            $display("%0t: occupied_count expected %0d actual %0d", $time, o.occ, occ);
            errors++;
        end
        if (o.fails !== fails) begin
            $display("%0t: failed_inserts expected %0d actual %0d", $time, o.fails, fails);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import cfe_pkg::*;

    logic clk;
    logic rst_n;
    logic calm;
    int   sent;

    cfe_req_if req ();
    cfe_rsp_if rsp ();
    cfe_cfg_if cfg ();

    filter_scoreboard board;

    cuckoo_filter_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function bit lull();
        return !calm && ($urandom_range(99) < 24);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_response(rsp.success, rsp.occupied_count, rsp.failed_inserts);
    end

    always @(negedge clk)
    begin
        if (!rst_n) rsp.ready <= 1'b0;
        else rsp.ready <= !lull();
    end

    // The request stays on the wires until the next call or a drain lowers valid.
    task automatic send_request(op_t op, logic [31:0] h);
        while (lull())
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.key_hash <= h;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        board.note_request(op, h);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [31:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        board.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_geometry(logic [3:0] lg, logic [2:0] sl, logic [9:0] kk,
                                logic [31:0] seed);
        drain();
        write_cfg(CFG_BUCKET_LOG2, 32'(lg));
        write_cfg(CFG_SLOTS, 32'(sl));
        write_cfg(CFG_MAX_KICKS, 32'(kk));
        write_cfg(CFG_SEED, seed);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int key_span);
        logic [31:0] keys [$];
        logic [31:0] h;
        int r;
        for (int i = 0; i < count; i++) begin
            calm = (i % 200) >= 150;
            r = $urandom_range(99);
            if (keys.size() == 0 || r < 45) begin
                h = (key_span == 0) ? $urandom() : $urandom_range(key_span);
                if (r == 0) h = $urandom() & 32'hffff_0000;
                keys.push_back(h);
                send_request(OP_INSERT, h);
            end
            else if (r < 70)
                send_request(OP_LOOKUP, keys[$urandom_range(keys.size() - 1)]);
            else if (r < 92)
                send_request(OP_REMOVE, keys[$urandom_range(keys.size() - 1)]);
            else if (r < 95)
                send_request(OP_NONE, $urandom());
            else
                send_request(op_t'($urandom_range(2)), $urandom());
        end
        calm = 1'b0;
    endtask

    initial
    begin
        board = new();
        calm = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_INSERT;
        req.key_hash = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_BUCKET_LOG2;
        cfg.data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_0001);
        send_request(OP_INSERT, 32'hffff_ffff);
        send_request(OP_LOOKUP, 32'hffff_ffff);
        send_request(OP_REMOVE, 32'hffff_ffff);
        send_request(OP_REMOVE, 32'hffff_ffff);
        send_request(OP_NONE, 32'h1234_5678);
        send_request(OP_INSERT, 32'haaaa_5555);
        send_request(OP_LOOKUP, 32'h5555_aaaa);

        set_geometry(4'd1, 3'd1, 10'd0, 32'd0);
        for (int i = 0; i < 6; i++) send_request(OP_INSERT, 32'h0000_0100 + i);
        send_request(OP_LOOKUP, 32'h0000_0102);
        set_geometry(4'd0, 3'd0, 10'd3, 32'hffff_ffff);
        for (int i = 0; i < 5; i++) send_request(OP_INSERT, 32'h0000_0200 + i * 7);
        set_geometry(4'd15, 3'd7, 10'd1023, 32'h8000_0001);
        send_request(OP_INSERT, 32'hdead_beef);
        send_request(OP_REMOVE, 32'hdead_beef);

        set_geometry(4'd2, 3'd2, 10'd8, $urandom());
        random_phase(350, 0);
        set_geometry(4'd3, 3'd4, 10'd40, $urandom());
        random_phase(350, 4095);
        set_geometry(4'd10, 3'd4, 10'd500, $urandom());
        random_phase(350, 0);
        set_geometry(4'd5, 3'd3, 10'd1023, $urandom());
        random_phase(300, 0);
        set_geometry(4'($urandom_range(1, 10)), 3'($urandom_range(1, 4)),
                     10'($urandom_range(0, 60)), $urandom());
        random_phase(380, 0);

        drain();
        $display("Covered %0d transactions, %0d responses checked, over several table sizes,",
                 sent, board.checked);
        $display("slot counts, kick limits and seeds, including overflowing small tables.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: files.f
rtl/cfe_pkg.sv
rtl/cfe_if.sv
rtl/cfe_ctrl.sv
rtl/cfe_dp.sv
rtl/cuckoo_filter_engine_unit.sv
tb/tb_top.sv
